// File: sv/pidh_pkg.sv
// Shared widths, register indexes and helpers for the PID controller with derivative hold.
`timescale 1ns / 1ps
`default_nettype none

package pidh_pkg;

   localparam int DATA_WIDTH     = 16;
   localparam int GAIN_FRAC_BITS = 8;
   localparam int GAIN_W         = 16;
   localparam int ERR_W          = DATA_WIDTH + 1;
   localparam int DIFF_W         = DATA_WIDTH + 2;
   localparam int SGAIN_W        = GAIN_W + 1;
   localparam int ACC_W          = SGAIN_W + DIFF_W + 2;
   localparam int SHIFT_W        = ACC_W - GAIN_FRAC_BITS;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_ADDR_W     = CSR_INDEX_W + 2;

   localparam logic signed [DATA_WIDTH-1:0] OUT_MAX_RESET = DATA_WIDTH'(255);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PROP_GAIN  = 3'd0,
      REG_INTEG_GAIN = 3'd1,
      REG_DERIV_GAIN = 3'd2,
      REG_OUT_MIN    = 3'd3,
      REG_OUT_MAX    = 3'd4,
      REG_REVERSE    = 3'd5,
      REG_AUTO_MODE  = 3'd6
   } csr_index_type;

   // Applies the gain sign for a reverse-acting process.
   function automatic logic signed [SGAIN_W-1:0] signed_gain(
      input logic [GAIN_W-1:0] gain,
      input logic              reverse
   );
      logic signed [SGAIN_W-1:0] g;
      g = $signed({1'b0, gain});
      return reverse ? -g : g;
   endfunction

endpackage

`default_nettype wire

// File: sv/pid_controller_with_derivative_hold_top.sv
// Top level of the PID controller with derivative hold: register port and four-register pipeline.
// A sample goes from the input register through the error and product registers to the output.
// Throughput: one sample per cycle while rsp_stall is low; the state loop (error, integral
// clamp, held difference) closes in the error stage; the three gain products get their own stage.
// Reset (synchronous, active high) empties the pipeline, clears integral, previous error,
// held difference and the init flag, and loads the registers: gains 0, limits 0 and 255,
// forward direction, manual mode.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_with_derivative_hold_top import pidh_pkg::*; (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0]        csr_paddr,
   input  wire  [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  signed [DATA_WIDTH-1:0] req_measured,
   input  wire  signed [DATA_WIDTH-1:0] req_target,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_drive,
   output logic                         rsp_computed,
   output logic signed [DIFF_W-1:0]     rsp_used_difference
);

   logic [GAIN_W-1:0]            prop_gain_ff;
   logic [GAIN_W-1:0]            integ_gain_ff;
   logic [GAIN_W-1:0]            deriv_gain_ff;
   logic signed [DATA_WIDTH-1:0] out_min_ff;
   logic signed [DATA_WIDTH-1:0] out_max_ff;
   logic                         reverse_ff;
   logic                         auto_mode_ff;

   logic signed [DATA_WIDTH-1:0] integral_ff;
   logic signed [ERR_W-1:0]      prev_error_ff;
   logic signed [DIFF_W-1:0]     held_diff_ff;
   logic                         init_pending_ff;

   logic                         in_valid_ff;
   logic signed [DATA_WIDTH-1:0] in_measured_ff;
   logic signed [DATA_WIDTH-1:0] in_target_ff;

   logic                         e_valid_ff;
   logic                         e_computed_ff;
   logic signed [ERR_W-1:0]      e_error_ff;
   logic signed [DATA_WIDTH-1:0] e_integral_ff;
   logic signed [DIFF_W-1:0]     e_diff_ff;

   logic                         p_valid_ff;
   logic                         p_computed_ff;
   logic signed [ACC_W-1:0]      p_prop_ff;
   logic signed [ACC_W-1:0]      p_integ_ff;
   logic signed [ACC_W-1:0]      p_deriv_ff;
   logic signed [DIFF_W-1:0]     p_diff_ff;

   logic                         out_valid_ff;
   logic signed [DATA_WIDTH-1:0] out_drive_ff;
   logic                         out_computed_ff;
   logic signed [DIFF_W-1:0]     out_diff_ff;

   logic                         csr_write;
   csr_index_type                csr_index;
   logic                         adv_out;
   logic                         adv_p;
   logic                         adv_e;
   logic                         adv_in;
   logic                         item_e;

   logic signed [ERR_W-1:0]      error_in;
   logic signed [ERR_W-1:0]      prev_used;
   logic signed [DIFF_W-1:0]     diff_raw;
   logic signed [DIFF_W-1:0]     diff_in;
   logic signed [DIFF_W-1:0]     integ_sum;
   logic signed [DATA_WIDTH-1:0] integral_in;
   logic signed [DIFF_W-1:0]     lim_lo_d;
   logic signed [DIFF_W-1:0]     lim_hi_d;

   logic signed [SGAIN_W-1:0]    kp_s;
   logic signed [SGAIN_W-1:0]    ki_s;
   logic signed [SGAIN_W-1:0]    kd_s;

   logic signed [ACC_W-1:0]      acc;
   logic signed [SHIFT_W-1:0]    shifted;
   logic signed [SHIFT_W-1:0]    lim_lo_s;
   logic signed [SHIFT_W-1:0]    lim_hi_s;
   logic signed [DATA_WIDTH-1:0] drive_in;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_PROP_GAIN:  csr_prdata = CSR_DATA_W'(prop_gain_ff);
         REG_INTEG_GAIN: csr_prdata = CSR_DATA_W'(integ_gain_ff);
         REG_DERIV_GAIN: csr_prdata = CSR_DATA_W'(deriv_gain_ff);
         REG_OUT_MIN:    csr_prdata = CSR_DATA_W'(out_min_ff);
         REG_OUT_MAX:    csr_prdata = CSR_DATA_W'(out_max_ff);
         REG_REVERSE:    csr_prdata = CSR_DATA_W'(reverse_ff);
         REG_AUTO_MODE:  csr_prdata = CSR_DATA_W'(auto_mode_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Each stage moves on when it is empty or the stage after it moves.
   assign adv_out   = !out_valid_ff || !rsp_stall;
   assign adv_p     = !p_valid_ff || adv_out;
   assign adv_e     = !e_valid_ff || adv_p;
   assign adv_in    = !in_valid_ff || adv_e;
   assign req_stall = !adv_in;
   assign item_e    = in_valid_ff && adv_e;

   // Error stage: the state loop closes here.
   assign error_in  = ERR_W'(in_target_ff) - ERR_W'(in_measured_ff);
   assign prev_used = init_pending_ff ? ERR_W'(in_measured_ff) : prev_error_ff;
   assign diff_raw  = DIFF_W'(error_in) - DIFF_W'(prev_used);
   assign diff_in   = (diff_raw != '0) ? diff_raw : held_diff_ff;
   assign integ_sum = DIFF_W'(integral_ff) + DIFF_W'(error_in);
   assign lim_lo_d  = DIFF_W'(out_min_ff);
   assign lim_hi_d  = DIFF_W'(out_max_ff);

   always_comb begin
      priority if (integ_sum > lim_hi_d) begin
         integral_in = out_max_ff;
      end else if (integ_sum < lim_lo_d) begin
         integral_in = out_min_ff;
      end else begin
         integral_in = DATA_WIDTH'(integ_sum);
      end
   end

   assign kp_s = signed_gain(prop_gain_ff, reverse_ff);
   assign ki_s = signed_gain(integ_gain_ff, reverse_ff);
   assign kd_s = signed_gain(deriv_gain_ff, reverse_ff);

   // Output stage: sum, floor shift and clamp; a manual-mode beat drives zero.
   assign acc      = p_prop_ff + p_integ_ff + p_deriv_ff;
   assign shifted  = SHIFT_W'(acc >>> GAIN_FRAC_BITS);
   assign lim_lo_s = SHIFT_W'(out_min_ff);
   assign lim_hi_s = SHIFT_W'(out_max_ff);

   always_comb begin
      priority if (!p_computed_ff) begin
         drive_in = '0;
      end else if (shifted > lim_hi_s) begin
         drive_in = out_max_ff;
      end else if (shifted < lim_lo_s) begin
         drive_in = out_min_ff;
      end else begin
         drive_in = DATA_WIDTH'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff    <= '0;
         integ_gain_ff   <= '0;
         deriv_gain_ff   <= '0;
         out_min_ff      <= '0;
         out_max_ff      <= OUT_MAX_RESET;
         reverse_ff      <= 1'b0;
         auto_mode_ff    <= 1'b0;
         integral_ff     <= '0;
         prev_error_ff   <= '0;
         held_diff_ff    <= '0;
         init_pending_ff <= 1'b0;
         in_valid_ff     <= 1'b0;
         e_valid_ff      <= 1'b0;
         p_valid_ff      <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (item_e && auto_mode_ff) begin
            integral_ff     <= integral_in;
            prev_error_ff   <= error_in;
            held_diff_ff    <= diff_in;
            init_pending_ff <= 1'b0;
         end
         if (csr_write) begin
            unique case (csr_index)
               REG_PROP_GAIN:  prop_gain_ff  <= csr_pwdata[GAIN_W-1:0];
               REG_INTEG_GAIN: integ_gain_ff <= csr_pwdata[GAIN_W-1:0];
               REG_DERIV_GAIN: deriv_gain_ff <= csr_pwdata[GAIN_W-1:0];
               REG_OUT_MIN:    out_min_ff    <= csr_pwdata[DATA_WIDTH-1:0];
               REG_OUT_MAX:    out_max_ff    <= csr_pwdata[DATA_WIDTH-1:0];
               REG_REVERSE:    reverse_ff    <= csr_pwdata[0];
               REG_AUTO_MODE: begin
                  if (csr_pwdata[0] && !auto_mode_ff) begin
                     integral_ff     <= '0;
                     init_pending_ff <= 1'b1;
                  end
                  auto_mode_ff <= csr_pwdata[0];
               end
               default: ;
            endcase
         end
         if (adv_in) begin
            in_valid_ff <= req_valid;
         end
         if (adv_e) begin
            e_valid_ff <= in_valid_ff;
         end
         if (adv_p) begin
            p_valid_ff <= e_valid_ff;
         end
         if (adv_out) begin
            out_valid_ff <= p_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in && req_valid) begin
         in_measured_ff <= req_measured;
         in_target_ff   <= req_target;
      end
      if (item_e) begin
         e_computed_ff <= auto_mode_ff;
         e_error_ff    <= error_in;
         e_integral_ff <= integral_in;
         e_diff_ff     <= auto_mode_ff ? diff_in : '0;
      end
      if (adv_p && e_valid_ff) begin
         p_computed_ff <= e_computed_ff;
         p_prop_ff     <= ACC_W'(kp_s) * ACC_W'(e_error_ff);
         p_integ_ff    <= ACC_W'(ki_s) * ACC_W'(e_integral_ff);
         p_deriv_ff    <= ACC_W'(kd_s) * ACC_W'(e_diff_ff);
         p_diff_ff     <= e_diff_ff;
      end
      if (adv_out && p_valid_ff) begin
         out_drive_ff    <= drive_in;
         out_computed_ff <= p_computed_ff;
         out_diff_ff     <= p_diff_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_drive           = out_drive_ff;
   assign rsp_computed        = out_computed_ff;
   assign rsp_used_difference = out_diff_ff;

   a_manual_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_computed |-> rsp_drive == '0 && rsp_used_difference == '0)
      else $error("A manual-mode beat carries a nonzero payload.");

   a_auto_entry: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_index == REG_AUTO_MODE && csr_pwdata[0] && !auto_mode_ff
      |=> init_pending_ff && integral_ff == '0 && auto_mode_ff)
      else $error("Entering automatic mode did not clear the integral.");

   a_init_consumed: assert property (@(posedge clock) disable iff (reset)
      item_e && auto_mode_ff |=> !init_pending_ff)
      else $error("The init flag survived a computed sample.");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("The input stage stalls while empty.");

endmodule

`default_nettype wire
